FILE: design/tpca_pkg.sv
// Shared types and constants for the touch point calibrate / average block.
// No dependencies; used by tpca_div, tpca_lane and touch_point_calibrate_average.
`default_nettype none
package tpca_pkg;

   localparam int PT_W          = 12;
   localparam int MAP_W         = 2 * PT_W;
   localparam int DIV_CNT_W     = $clog2(MAP_W + 1);
   localparam int THR_W         = 15;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 15;
   localparam int AVG_DEPTH_DEF = 4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_X_LOW   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_X_HIGH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_Y_LOW   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_Y_HIGH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_WIDTH   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_THRESH  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_OPTIONS = 3'd7;

   // option bits
   localparam int OPT_SWAP     = 0;
   localparam int OPT_INV_X    = 1;
   localparam int OPT_INV_Y    = 2;
   localparam int OPT_USE_IRQ  = 3;
   localparam int OPT_USE_PRES = 4;

   localparam logic [PT_W-1:0]  X_LOW_RST   = 12'd200;
   localparam logic [PT_W-1:0]  X_HIGH_RST  = 12'd3800;
   localparam logic [PT_W-1:0]  Y_LOW_RST   = 12'd200;
   localparam logic [PT_W-1:0]  Y_HIGH_RST  = 12'd3800;
   localparam logic [PT_W-1:0]  WIDTH_RST   = 12'd320;
   localparam logic [PT_W-1:0]  HEIGHT_RST  = 12'd240;
   localparam logic [THR_W-1:0] THRESH_RST  = 15'd400;
   localparam logic [4:0]       OPTIONS_RST = 5'd24;

   localparam logic signed [THR_W-1:0] PRES_OFFSET = 15'sd4096;

   typedef struct packed {
      logic [PT_W-1:0] lo;
      logic [PT_W-1:0] hi;
      logic [PT_W-1:0] res;
      logic            inv;
   } axis_cal_type;

   typedef struct packed {
      logic            done;
      logic [PT_W-1:0] point;
   } lane_status_type;

endpackage
`default_nettype wire

FILE: design/tpca_div.sv
// Restoring divider, one quotient bit per cycle, run for a given bit count.
// Depends on tpca_pkg for widths.
`default_nettype none
module tpca_div (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [tpca_pkg::MAP_W-1:0]      dividend,
   input  wire logic [tpca_pkg::PT_W-1:0]       divisor,
   input  wire logic [tpca_pkg::DIV_CNT_W-1:0]  iters,
   output logic                                 done,
   output logic [tpca_pkg::MAP_W-1:0]           quotient
);

   localparam int DW  = tpca_pkg::MAP_W;
   localparam int DVW = tpca_pkg::PT_W;
   localparam int CW  = tpca_pkg::DIV_CNT_W;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DVW-1:0] rem_ff, rem_in;
   logic [DVW-1:0] dvs_ff, dvs_in;
   logic [DW-1:0]  quo_ff, quo_in;
   logic [DVW:0]   trial;
   logic [DVW:0]   diff;
   logic           ge;

   assign trial = {rem_ff, quo_ff[DW-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign ge    = (trial >= {1'b0, dvs_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = iters;
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DVW-1:0] : trial[DVW-1:0];
         quo_in = {quo_ff[DW-2:0], ge};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

FILE: design/tpca_lane.sv
// One axis lane: calibrate, scale, clamp, invert, then running-sum average.
// Depends on tpca_pkg and tpca_div.
`default_nettype none
module tpca_lane #(
   parameter int AVG_DEPTH = tpca_pkg::AVG_DEPTH_DEF,
   parameter int FW        = $clog2(AVG_DEPTH + 1)
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [tpca_pkg::PT_W-1:0]    raw,
   input  wire tpca_pkg::axis_cal_type       cal,
   input  wire logic [FW-1:0]                fill_old,
   input  wire logic [FW-1:0]                fill_new,
   output tpca_pkg::lane_status_type         status
);

   localparam int PW = tpca_pkg::PT_W;
   localparam int DW = tpca_pkg::MAP_W;
   localparam int CW = tpca_pkg::DIV_CNT_W;
   localparam int SW = PW + $clog2(AVG_DEPTH);

   localparam logic [2:0] L_IDLE     = 3'd0;
   localparam logic [2:0] L_MUL      = 3'd1;
   localparam logic [2:0] L_MAP      = 3'd2;
   localparam logic [2:0] L_WAIT_MAP = 3'd3;
   localparam logic [2:0] L_AVG      = 3'd4;
   localparam logic [2:0] L_WAIT_AVG = 3'd5;

   logic [2:0]    state_ff, state_in;
   logic [PW-1:0] raw_ff, raw_in;
   logic [DW-1:0] prod_ff, prod_in;
   logic [PW-1:0] span_ff, span_in;
   logic          span_ok_ff, span_ok_in;
   logic [SW-1:0] sum_ff, sum_in;
   logic [PW-1:0] hist_ff [AVG_DEPTH];

   logic [PW-1:0] offs;
   logic [PW-1:0] sat;
   logic [PW-1:0] scaled;
   logic [PW-1:0] pt;
   logic [SW-1:0] base;
   logic          hist_shift;

   logic          div_start;
   logic [DW-1:0] div_dividend;
   logic [PW-1:0] div_divisor;
   logic [CW-1:0] div_iters;
   logic          div_done;
   logic [DW-1:0] div_quo;

   tpca_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .iters    (div_iters),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign offs   = (raw_ff > cal.lo) ? raw_ff - cal.lo : '0;
   assign sat    = (div_quo > DW'(cal.res)) ? cal.res : div_quo[PW-1:0];
   assign scaled = span_ok_ff ? sat : '0;
   assign pt     = cal.inv ? cal.res - scaled : scaled;

   always_comb begin
      if (fill_old == '0) begin
         base = '0;
      end else if (fill_old == FW'(AVG_DEPTH)) begin
         base = sum_ff - SW'(hist_ff[AVG_DEPTH-1]);
      end else begin
         base = sum_ff;
      end
   end

   assign div_start    = (state_ff == L_MAP) || (state_ff == L_AVG);
   assign div_dividend = (state_ff == L_MAP) ? prod_ff : (DW'(sum_ff) << (DW - SW));
   assign div_divisor  = (state_ff == L_MAP) ? span_ff : PW'(fill_new);
   assign div_iters    = (state_ff == L_MAP) ? CW'(DW) : CW'(SW);

   always_comb begin
      state_in   = state_ff;
      raw_in     = raw_ff;
      prod_in    = prod_ff;
      span_in    = span_ff;
      span_ok_in = span_ok_ff;
      sum_in     = sum_ff;
      hist_shift = 1'b0;
      unique case (state_ff)
         L_IDLE: begin
            if (start) begin
               raw_in   = raw;
               state_in = L_MUL;
            end
         end
         L_MUL: begin
            prod_in    = DW'(offs) * DW'(cal.res);
            span_in    = cal.hi - cal.lo;
            span_ok_in = (cal.hi > cal.lo);
            state_in   = L_MAP;
         end
         L_MAP: begin
            state_in = L_WAIT_MAP;
         end
         L_WAIT_MAP: begin
            if (div_done) begin
               hist_shift = 1'b1;
               sum_in     = base + SW'(pt);
               state_in   = L_AVG;
            end
         end
         L_AVG: begin
            state_in = L_WAIT_AVG;
         end
         L_WAIT_AVG: begin
            if (div_done) begin
               state_in = L_IDLE;
            end
         end
         default: begin
            state_in = L_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
      end else begin
         state_ff <= state_in;
      end
      raw_ff     <= raw_in;
      prod_ff    <= prod_in;
      span_ff    <= span_in;
      span_ok_ff <= span_ok_in;
      sum_ff     <= sum_in;
   end

   always_ff @(posedge clock) begin
      if (hist_shift) begin
         hist_ff[0] <= pt;
         for (int i = 1; i < AVG_DEPTH; i++) begin
            hist_ff[i] <= hist_ff[i-1];
         end
      end
   end

   assign status = '{done: (state_ff == L_WAIT_AVG) && div_done, point: div_quo[PW-1:0]};

endmodule
`default_nettype wire

FILE: design/touch_point_calibrate_average.sv
// Top level: registers, touch test, X and Y lanes, merge and result word.
// Depends on tpca_pkg and tpca_lane.
//
//   port group  dir   what
//   req_*       in    touch sample word (irq level, raw X/Y/Z1/Z2), valid/stall
//   rsp_*       out   point word (X, Y, pressed), valid/stall
//   csr_*       in    register write, index and data
//
// A touched sample is paced by each lane's bit-serial divider: a scale pass then an
// average pass. A released sample skips the lanes and goes straight to the output
// stage. One sample is worked on at a time.
// The result word waits in an output register; req_stall is high while busy.
// Synchronous active-high reset restores register defaults and empties history.
`default_nettype none
module touch_point_calibrate_average #(
   parameter int AVG_DEPTH = tpca_pkg::AVG_DEPTH_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic                                 req_irq_level,
   input  wire logic [15:0]                          req_raw_x_word,
   input  wire logic [15:0]                          req_raw_y_word,
   input  wire logic [15:0]                          req_raw_z1_word,
   input  wire logic [15:0]                          req_raw_z2_word,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [tpca_pkg::PT_W-1:0]                 rsp_point_x,
   output logic [tpca_pkg::PT_W-1:0]                 rsp_point_y,
   output logic                                      rsp_pressed,
   input  wire logic                                 csr_write,
   input  wire logic [tpca_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [tpca_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int PW = tpca_pkg::PT_W;
   localparam int TW = tpca_pkg::THR_W;
   localparam int FW = $clog2(AVG_DEPTH + 1);

   localparam logic [1:0] T_IDLE = 2'd0;
   localparam logic [1:0] T_RUN  = 2'd1;
   localparam logic [1:0] T_HOLD = 2'd2;

   logic [PW-1:0] x_low_ff, x_high_ff, y_low_ff, y_high_ff;
   logic [PW-1:0] width_ff, height_ff;
   logic [TW-1:0] thresh_ff;
   logic [4:0]    options_ff;

   logic [1:0]    state_ff, state_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [FW-1:0] fill_new;
   logic [PW-1:0] held_x_ff, held_x_in;
   logic [PW-1:0] held_y_ff, held_y_in;
   logic          pressed_ff, pressed_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0] rsp_x_ff, rsp_x_in;
   logic [PW-1:0] rsp_y_ff, rsp_y_in;
   logic          rsp_pressed_ff, rsp_pressed_in;

   logic                     accept;
   logic                     touch;
   logic signed [TW-1:0]     pres;
   logic [PW-1:0]            raw_x, raw_y;
   logic [PW-1:0]            lane_x_raw, lane_y_raw;
   logic                     lane_start;
   tpca_pkg::axis_cal_type   cal_x, cal_y;
   tpca_pkg::lane_status_type stat_x, stat_y;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         x_low_ff   <= tpca_pkg::X_LOW_RST;
         x_high_ff  <= tpca_pkg::X_HIGH_RST;
         y_low_ff   <= tpca_pkg::Y_LOW_RST;
         y_high_ff  <= tpca_pkg::Y_HIGH_RST;
         width_ff   <= tpca_pkg::WIDTH_RST;
         height_ff  <= tpca_pkg::HEIGHT_RST;
         thresh_ff  <= tpca_pkg::THRESH_RST;
         options_ff <= tpca_pkg::OPTIONS_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            tpca_pkg::REG_X_LOW:   x_low_ff   <= csr_wdata[PW-1:0];
            tpca_pkg::REG_X_HIGH:  x_high_ff  <= csr_wdata[PW-1:0];
            tpca_pkg::REG_Y_LOW:   y_low_ff   <= csr_wdata[PW-1:0];
            tpca_pkg::REG_Y_HIGH:  y_high_ff  <= csr_wdata[PW-1:0];
            tpca_pkg::REG_WIDTH:   width_ff   <= csr_wdata[PW-1:0];
            tpca_pkg::REG_HEIGHT:  height_ff  <= csr_wdata[PW-1:0];
            tpca_pkg::REG_THRESH:  thresh_ff  <= csr_wdata[TW-1:0];
            tpca_pkg::REG_OPTIONS: options_ff <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   // touch test
   assign pres = $signed({2'b00, req_raw_z1_word[15:3]}) + tpca_pkg::PRES_OFFSET
               - $signed({2'b00, req_raw_z2_word[15:3]});

   always_comb begin
      touch = 1'b1;
      if (options_ff[tpca_pkg::OPT_USE_IRQ] && req_irq_level) begin
         touch = 1'b0;
      end
      if (options_ff[tpca_pkg::OPT_USE_PRES] && (pres < $signed(thresh_ff))) begin
         touch = 1'b0;
      end
   end

   assign raw_x      = req_raw_x_word[15:4];
   assign raw_y      = req_raw_y_word[15:4];
   assign lane_x_raw = options_ff[tpca_pkg::OPT_SWAP] ? raw_y : raw_x;
   assign lane_y_raw = options_ff[tpca_pkg::OPT_SWAP] ? raw_x : raw_y;

   assign accept     = req_valid && !req_stall;
   assign lane_start = accept && touch;
   assign fill_new   = (fill_ff == FW'(AVG_DEPTH)) ? fill_ff : fill_ff + FW'(1);

   assign cal_x = '{lo: x_low_ff, hi: x_high_ff, res: width_ff,
                    inv: options_ff[tpca_pkg::OPT_INV_X]};
   assign cal_y = '{lo: y_low_ff, hi: y_high_ff, res: height_ff,
                    inv: options_ff[tpca_pkg::OPT_INV_Y]};

   tpca_lane #(.AVG_DEPTH(AVG_DEPTH), .FW(FW)) u_lane_x (
      .clock    (clock),
      .reset    (reset),
      .start    (lane_start),
      .raw      (lane_x_raw),
      .cal      (cal_x),
      .fill_old (fill_ff),
      .fill_new (fill_new),
      .status   (stat_x)
   );

   tpca_lane #(.AVG_DEPTH(AVG_DEPTH), .FW(FW)) u_lane_y (
      .clock    (clock),
      .reset    (reset),
      .start    (lane_start),
      .raw      (lane_y_raw),
      .cal      (cal_y),
      .fill_old (fill_ff),
      .fill_new (fill_new),
      .status   (stat_y)
   );

   // sequencing and merge; both lanes run in lock step
   always_comb begin
      state_in       = state_ff;
      fill_in        = fill_ff;
      held_x_in      = held_x_ff;
      held_y_in      = held_y_ff;
      pressed_in     = pressed_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_x_in       = rsp_x_ff;
      rsp_y_in       = rsp_y_ff;
      rsp_pressed_in = rsp_pressed_ff;
      unique case (state_ff)
         T_IDLE: begin
            if (accept) begin
               if (touch) begin
                  state_in = T_RUN;
               end else begin
                  fill_in    = '0;
                  pressed_in = 1'b0;
                  state_in   = T_HOLD;
               end
            end
         end
         T_RUN: begin
            if (stat_x.done && stat_y.done) begin
               held_x_in  = stat_x.point;
               held_y_in  = stat_y.point;
               fill_in    = fill_new;
               pressed_in = 1'b1;
               state_in   = T_HOLD;
            end
         end
         T_HOLD: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_x_in       = held_x_ff;
               rsp_y_in       = held_y_ff;
               rsp_pressed_in = pressed_ff;
               state_in       = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         fill_ff      <= '0;
         held_x_ff    <= '0;
         held_y_ff    <= '0;
         pressed_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         held_x_ff    <= held_x_in;
         held_y_ff    <= held_y_in;
         pressed_ff   <= pressed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_x_ff       <= rsp_x_in;
      rsp_y_ff       <= rsp_y_in;
      rsp_pressed_ff <= rsp_pressed_in;
   end

   assign req_stall   = (state_ff != T_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_point_x = rsp_x_ff;
   assign rsp_point_y = rsp_y_ff;
   assign rsp_pressed = rsp_pressed_ff;

endmodule
`default_nettype wire

FILE: test/tpca_point_checker.sv
// Watches the sample, point and register ports of touch_point_calibrate_average,
// predicts each point word from its own calibration and averaging state, and counts mismatches.
// Depends on tpca_pkg.
`timescale 1ns / 1ps
module tpca_point_checker #(
   parameter int AVG_DEPTH = tpca_pkg::AVG_DEPTH_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   input  wire logic                                 req_stall,
   input  wire logic                                 req_irq_level,
   input  wire logic [15:0]                          req_raw_x_word,
   input  wire logic [15:0]                          req_raw_y_word,
   input  wire logic [15:0]                          req_raw_z1_word,
   input  wire logic [15:0]                          req_raw_z2_word,
   input  wire logic                                 rsp_valid,
   input  wire logic                                 rsp_stall,
   input  wire logic [tpca_pkg::PT_W-1:0]            rsp_point_x,
   input  wire logic [tpca_pkg::PT_W-1:0]            rsp_point_y,
   input  wire logic                                 rsp_pressed,
   input  wire logic                                 csr_write,
   input  wire logic [tpca_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [tpca_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output int                                        fail_count,
   output int                                        pending,
   output int                                        touch_count
);

   localparam int PW = tpca_pkg::PT_W;

   typedef struct packed {
      logic [PW-1:0] x;
      logic [PW-1:0] y;
      logic          pressed;
   } point_word_type;

   point_word_type  expected_points[$];
   logic [PW-1:0]   cal_x_lo, cal_x_hi, cal_y_lo, cal_y_hi, scr_w, scr_h;
   int              thresh;
   logic [4:0]      opts;
   logic [PW-1:0]   x_hist[AVG_DEPTH];
   logic [PW-1:0]   y_hist[AVG_DEPTH];
   int              fill;
   logic [PW-1:0]   hold_x, hold_y;
   int              mismatches = 0;
   int              touches = 0;
   int              words_seen = 0;

   function automatic logic [PW-1:0] scale_axis(int raw, int lo, int hi, int res, logic inv);
      int v;
      int s;
      v = (raw > lo) ? raw - lo : 0;
      s = 0;
      if (hi > lo) begin
         s = (v * res) / (hi - lo);
         if (s > res) s = res;
      end
      if (inv) s = res - s;
      return s[PW-1:0];
   endfunction

   function automatic logic pen_down(logic irq, logic [15:0] z1, logic [15:0] z2);
      int figure;
      if (opts[tpca_pkg::OPT_USE_IRQ] && irq) return 1'b0;
      if (opts[tpca_pkg::OPT_USE_PRES]) begin
         figure = int'(z1 >> 3) + 4096 - int'(z2 >> 3);
         if (figure < thresh) return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic average_point(input logic irq, input logic [15:0] rx, input logic [15:0] ry,
                                input logic [15:0] z1, input logic [15:0] z2,
                                output point_word_type pw);
      logic [PW-1:0] ax, ay, t;
      int            sx, sy;
      if (pen_down(irq, z1, z2)) begin
         ax = rx[15:4];
         ay = ry[15:4];
         if (opts[tpca_pkg::OPT_SWAP]) begin
            t  = ax;
            ax = ay;
            ay = t;
         end
         ax = scale_axis(ax, cal_x_lo, cal_x_hi, scr_w, opts[tpca_pkg::OPT_INV_X]);
         ay = scale_axis(ay, cal_y_lo, cal_y_hi, scr_h, opts[tpca_pkg::OPT_INV_Y]);
         for (int i = AVG_DEPTH - 1; i > 0; i--) begin
            x_hist[i] = x_hist[i-1];
            y_hist[i] = y_hist[i-1];
         end
         x_hist[0] = ax;
         y_hist[0] = ay;
         if (fill < AVG_DEPTH) fill++;
         sx = 0;
         sy = 0;
         for (int i = 0; i < fill; i++) begin
            sx += x_hist[i];
            sy += y_hist[i];
         end
         hold_x = PW'(sx / fill);
         hold_y = PW'(sy / fill);
         pw.pressed = 1'b1;
      end else begin
         fill = 0;
         pw.pressed = 1'b0;
      end
      pw.x = hold_x;
      pw.y = hold_y;
   endtask

   always @(posedge clock) begin : watch
      point_word_type pw;
      point_word_type got;
      if (reset) begin
         cal_x_lo = tpca_pkg::X_LOW_RST;
         cal_x_hi = tpca_pkg::X_HIGH_RST;
         cal_y_lo = tpca_pkg::Y_LOW_RST;
         cal_y_hi = tpca_pkg::Y_HIGH_RST;
         scr_w    = tpca_pkg::WIDTH_RST;
         scr_h    = tpca_pkg::HEIGHT_RST;
         thresh   = $signed(tpca_pkg::THRESH_RST);
         opts     = tpca_pkg::OPTIONS_RST;
         fill     = 0;
         hold_x   = '0;
         hold_y   = '0;
         for (int i = 0; i < AVG_DEPTH; i++) begin
            x_hist[i] = '0;
            y_hist[i] = '0;
         end
         expected_points.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               tpca_pkg::REG_X_LOW:   cal_x_lo = csr_wdata[PW-1:0];
               tpca_pkg::REG_X_HIGH:  cal_x_hi = csr_wdata[PW-1:0];
               tpca_pkg::REG_Y_LOW:   cal_y_lo = csr_wdata[PW-1:0];
               tpca_pkg::REG_Y_HIGH:  cal_y_hi = csr_wdata[PW-1:0];
               tpca_pkg::REG_WIDTH:   scr_w    = csr_wdata[PW-1:0];
               tpca_pkg::REG_HEIGHT:  scr_h    = csr_wdata[PW-1:0];
               tpca_pkg::REG_THRESH:  thresh   = $signed(csr_wdata);
               tpca_pkg::REG_OPTIONS: opts     = csr_wdata[4:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            average_point(req_irq_level, req_raw_x_word, req_raw_y_word,
                          req_raw_z1_word, req_raw_z2_word, pw);
            expected_points.push_back(pw);
            if (pw.pressed) touches++;
         end
         if (rsp_valid && !rsp_stall) begin
            got.x       = rsp_point_x;
            got.y       = rsp_point_y;
            got.pressed = rsp_pressed;
            words_seen++;
            if (expected_points.size() == 0) begin
               if (mismatches < 10)
                  $display("point word %0d: none expected, got x=%0d y=%0d pressed=%0b",
                           words_seen, got.x, got.y, got.pressed);
               mismatches++;
            end else begin
               pw = expected_points.pop_front();
               if (got.x !== pw.x || got.y !== pw.y || got.pressed !== pw.pressed) begin
                  if (mismatches < 10)
                     $display({"point word %0d: expected x=%0d y=%0d pressed=%0b, ",
                               "got x=%0d y=%0d pressed=%0b"},
                              words_seen, pw.x, pw.y, pw.pressed, got.x, got.y, got.pressed);
                  mismatches++;
               end
            end
         end
      end
      pending     <= expected_points.size();
      fail_count  <= mismatches;
      touch_count <= touches;
   end

endmodule

FILE: test/tb_top.sv
// Stimulus and verdict for touch_point_calibrate_average: directed samples, then random
// touch strokes under random calibrations, with random idling on both sides.
// Depends on tpca_pkg, the block, and tpca_point_checker.
`timescale 1ns / 1ps
module tb_top;

   localparam int LIMIT    = 200000;
   localparam int HOLD_LEN = 300;
   localparam int CSR_DW   = tpca_pkg::CSR_DATA_W;
   localparam int OPT_ALL  = (1 << tpca_pkg::OPT_SWAP) | (1 << tpca_pkg::OPT_INV_X)
                           | (1 << tpca_pkg::OPT_INV_Y) | (1 << tpca_pkg::OPT_USE_IRQ)
                           | (1 << tpca_pkg::OPT_USE_PRES);

   typedef struct {
      int x_lo;
      int x_hi;
      int y_lo;
      int y_hi;
      int width;
      int height;
      int thresh;
      int opts;
   } cal_settings_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_irq_level = 1'b1;
   logic [15:0]                     req_raw_x_word = '0;
   logic [15:0]                     req_raw_y_word = '0;
   logic [15:0]                     req_raw_z1_word = '0;
   logic [15:0]                     req_raw_z2_word = '0;
   logic                            rsp_stall = 1'b0;
   logic                            csr_write = 1'b0;
   logic [tpca_pkg::CSR_IDX_W-1:0]  csr_index = tpca_pkg::REG_X_LOW;
   logic [CSR_DW-1:0]               csr_wdata = '0;
   logic                            req_stall;
   logic                            rsp_valid;
   logic [tpca_pkg::PT_W-1:0]       rsp_point_x;
   logic [tpca_pkg::PT_W-1:0]       rsp_point_y;
   logic                            rsp_pressed;

   int fail_count;
   int pending;
   int touch_count;
   int cycle_count = 0;
   int hold_cycles = 0;
   bit quiet = 1'b0;
   int samples_sent = 0;
   int settings_used = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   touch_point_calibrate_average DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_irq_level   (req_irq_level),
      .req_raw_x_word  (req_raw_x_word),
      .req_raw_y_word  (req_raw_y_word),
      .req_raw_z1_word (req_raw_z1_word),
      .req_raw_z2_word (req_raw_z2_word),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_point_x     (rsp_point_x),
      .rsp_point_y     (rsp_point_y),
      .rsp_pressed     (rsp_pressed),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   tpca_point_checker u_point_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_irq_level   (req_irq_level),
      .req_raw_x_word  (req_raw_x_word),
      .req_raw_y_word  (req_raw_y_word),
      .req_raw_z1_word (req_raw_z1_word),
      .req_raw_z2_word (req_raw_z2_word),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_point_x     (rsp_point_x),
      .rsp_point_y     (rsp_point_y),
      .rsp_pressed     (rsp_pressed),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .pending         (pending),
      .touch_count     (touch_count)
   );

   // receiver: random stall, none while quiet, one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles--;
         end else begin
            rsp_stall <= !quiet && ($urandom_range(0, 99) < 19);
         end
      end
   end

   initial begin
      while (cycle_count < LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timed out after %0d cycles, %0d point words outstanding", cycle_count, pending);
      $display("touch_point_calibrate_average: mismatch");
      $finish;
   end

   task automatic drive_sample(input logic irq, input logic [15:0] x, input logic [15:0] y,
                               input logic [15:0] z1, input logic [15:0] z2);
      while (!quiet && $urandom_range(0, 99) < 19) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_irq_level   <= irq;
      req_raw_x_word  <= x;
      req_raw_y_word  <= y;
      req_raw_z1_word <= z1;
      req_raw_z2_word <= z2;
      do @(posedge clock); while (req_stall);
      samples_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic put_reg(input logic [tpca_pkg::CSR_IDX_W-1:0] idx, input int value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DW'(value);
      @(posedge clock);
   endtask

   task automatic program_settings(input cal_settings_type s);
      put_reg(tpca_pkg::REG_X_LOW, s.x_lo);
      put_reg(tpca_pkg::REG_X_HIGH, s.x_hi);
      put_reg(tpca_pkg::REG_Y_LOW, s.y_lo);
      put_reg(tpca_pkg::REG_Y_HIGH, s.y_hi);
      put_reg(tpca_pkg::REG_WIDTH, s.width);
      put_reg(tpca_pkg::REG_HEIGHT, s.height);
      put_reg(tpca_pkg::REG_THRESH, s.thresh);
      put_reg(tpca_pkg::REG_OPTIONS, s.opts);
      csr_write <= 1'b0;
      settings_used++;
   endtask

   function automatic void pick_span(output int lo, output int hi);
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         lo = $urandom_range(0, 4095);
         hi = lo;
      end else if (r < 20) begin
         lo = $urandom_range(1, 4095);
         hi = $urandom_range(0, lo - 1);
      end else if (r < 30) begin
         lo = 0;
         hi = 4095;
      end else begin
         lo = $urandom_range(0, 3000);
         hi = $urandom_range(lo + 1, 4095);
      end
   endfunction

   function automatic int pick_res();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 1;
      if (r < 20) return 4095;
      return $urandom_range(1, 4095);
   endfunction

   function automatic cal_settings_type random_settings();
      cal_settings_type s;
      int               r;
      pick_span(s.x_lo, s.x_hi);
      pick_span(s.y_lo, s.y_hi);
      s.width  = pick_res();
      s.height = pick_res();
      r = $urandom_range(0, 99);
      if (r < 10)      s.thresh = -4096;
      else if (r < 20) s.thresh = 12287;
      else             s.thresh = int'($urandom_range(0, 16383)) - 4096;
      s.opts = $urandom_range(0, OPT_ALL);
      return s;
   endfunction

   // strokes of pen-down samples closed by a lift, with some plain noise
   task automatic send_random_items(input int count);
      int          sent;
      int          run;
      logic [15:0] z1;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 99) < 80) begin
            run = $urandom_range(1, 8);
            for (int i = 0; i < run; i++) begin
               z1 = $urandom_range(0, 65535);
               drive_sample(1'b0, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                            z1, 16'($urandom_range(0, z1)));
            end
            drive_sample(1'b1, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                         16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
            sent += run + 1;
         end else begin
            drive_sample(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                         16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                         16'($urandom_range(0, 65535)));
            sent++;
         end
      end
   endtask

   initial begin
      cal_settings_type s;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset calibration, IRQ and pressure both in use
      drive_sample(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      drive_sample(1'b0, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000);
      drive_sample(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
      drive_sample(1'b0, 16'h8000, 16'h4000, 16'h1000, 16'h1000);
      drive_sample(1'b0, 16'h7FF0, 16'h0010, 16'hFFFF, 16'h0000);
      drive_sample(1'b0, 16'h5A5F, 16'hA5A0, 16'hFFFF, 16'h0007);
      drive_sample(1'b0, 16'h3333, 16'hCCCC, 16'hFFFF, 16'h0000);
      drive_sample(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
      drive_sample(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
      drive_sample(1'b0, 16'h8000, 16'h8000, 16'hFFFF, 16'h0000);

      // reversed Y span, full width, unit height, lowest threshold, swap and invert
      drain();
      s = '{0, 4095, 4095, 0, 4095, 1, -4096,
            (1 << tpca_pkg::OPT_SWAP) | (1 << tpca_pkg::OPT_INV_X)
            | (1 << tpca_pkg::OPT_INV_Y) | (1 << tpca_pkg::OPT_USE_PRES)};
      program_settings(s);
      drive_sample(1'b0, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
      drive_sample(1'b1, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
      drive_sample(1'b1, 16'hFFF0, 16'h000F, 16'hFFFF, 16'hFFFF);

      // zero X span, highest threshold: only the strongest pressure counts
      drain();
      s = '{2048, 2048, 0, 4095, 1, 4095, 12287,
            (1 << tpca_pkg::OPT_USE_IRQ) | (1 << tpca_pkg::OPT_USE_PRES)};
      program_settings(s);
      drive_sample(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
      drive_sample(1'b0, 16'hFFFF, 16'h8000, 16'hFFFF, 16'h0008);
      drive_sample(1'b0, 16'h1234, 16'h4321, 16'hFFFF, 16'h0007);
      drive_sample(1'b1, 16'h1234, 16'h4321, 16'hFFFF, 16'h0000);

      // no touch test at all
      drain();
      s = '{200, 3800, 200, 3800, 320, 240, 400, 0};
      program_settings(s);
      drive_sample(1'b1, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
      drive_sample(1'b1, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);

      for (int p = 0; p < 8; p++) begin
         drain();
         s = random_settings();
         if (p == 7) s.opts = OPT_ALL;
         program_settings(s);
         if (p == 2) hold_cycles = HOLD_LEN;
         quiet = (p == 4);
         send_random_items(48);
      end
      quiet = 1'b0;

      drain();
      repeat (48) @(posedge clock);
      $display("run covered %0d samples, %0d of them read as touches, under %0d register settings",
               samples_sent, touch_count, settings_used);
      $display("with random idling, a quiet stretch and a %0d-cycle receiver hold-off", HOLD_LEN);
      if (fail_count == 0 && pending == 0) begin
         $display("touch_point_calibrate_average: match");
      end else begin
         $display("touch_point_calibrate_average: mismatch");
      end
      $finish;
   end

endmodule

FILE: touch_point_calibrate_average.f
design/tpca_pkg.sv
design/tpca_div.sv
design/tpca_lane.sv
design/touch_point_calibrate_average.sv
test/tpca_point_checker.sv
test/tb_top.sv
